### src/hida_pkg.sv
// Package for the handle id allocator table.
// Holds the item structs, action codes and the controller/datapath command and status types.
// No dependencies.
package hida_pkg;

    // Action codes carried in the action field of an input item.
    localparam logic [2:0] ACT_CREATE  = 3'd0;
    localparam logic [2:0] ACT_CLOSE   = 3'd1;
    localparam logic [2:0] ACT_LOOKUP  = 3'd2;
    localparam logic [2:0] ACT_REVERSE = 3'd3;
    localparam logic [2:0] ACT_CLEAR   = 3'd4;

    // One request item.
    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] object_ref;
        logic [8:0]  handle_id;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic        ok;
        logic [8:0]  result_id;
        logic [31:0] result_ref;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan;
        logic sweep_start;
        logic sweep;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] action;
        logic       full;
        logic       key_null;
        logic       hid_ok;
        logic       hit;
        logic       miss_done;
        logic       sweep_last;
        logic       out_free;
    } t_dp_stat;

endpackage

### src/handle_id_allocator_table.sv
// Top level of the handle id allocator table: controller plus datapath.
// Depends on hida_pkg, hida_ctrl and hida_dpath.
//
//   Channel   Direction   Handshake                   Payload
//   request   in          i_in_valid / o_in_stall     i_in_item  (t_in_item)
//   result    out         o_out_valid / i_out_stall   o_out_item (t_out_item)
//
// One item is worked at a time. Close and lookup read the one addressed entry;
// create and reverse lookup scan up to NUM_IDS entries through the single memory
// read port, and clear sweeps the valid bits. After reset the block holds the
// request side off while it sweeps the valid bits. A stalled result waits in the
// output register; the next item is taken meanwhile and its result waits until
// that register frees up.
module handle_id_allocator_table
    import hida_pkg::*;
#(
    parameter int NUM_IDS  = 256,
    parameter int REF_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer.
    hida_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Table storage and result path.
    hida_dpath #(
        .NUM_IDS  (NUM_IDS),
        .REF_BITS (REF_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // An accepted item blocks the request side on the next cycle.
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request side open right after an accepted item");

    // A failed action reports no id and no reference.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.ok) |->
        (o_out_item.result_id == 9'd0 && o_out_item.result_ref == 32'd0))
        else $error("failed result carries a nonzero field");

    // No action reports both an id and a reference.
    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.result_id == 9'd0 || o_out_item.result_ref == 32'd0))
        else $error("result carries both an id and a reference");

    // A new result only appears after the controller finished an item.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.finish))
        else $error("result appeared without a finish command");

endmodule

### src/hida_dpath.sv
// Datapath of the handle id allocator table: entry memories, scan pipeline,
// allocation counters and the result register.
// Depends on hida_pkg.
module hida_dpath
    import hida_pkg::*;
#(
    parameter int NUM_IDS  = 256,
    parameter int REF_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int AW = $clog2(NUM_IDS);
    localparam int IW = $clog2(NUM_IDS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_IDS - 1);
    localparam logic [IW-1:0] NUM_IDS_W = IW'(NUM_IDS);

    // Latched request.
    logic [2:0]          r_action;
    logic [REF_BITS-1:0] r_key;
    logic [8:0]          r_hid;

    // Allocation state.
    logic [IW-1:0] r_next_id, n_next_id;
    logic          r_wrapped, n_wrapped;
    logic [IW-1:0] r_live, n_live;

    // Scan and sweep address, issue count and read stage.
    logic [AW-1:0]       r_addr;
    logic [IW-1:0]       r_cnt;
    logic                r_pend;
    logic                r_last;
    logic [AW-1:0]       r_rd_addr;
    logic                r_rd_vbit;
    logic [REF_BITS-1:0] r_rd_ref;

    // Captured hit.
    logic                r_found;
    logic [AW-1:0]       r_hit_addr;
    logic [REF_BITS-1:0] r_hit_ref;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out;

    // Entry memories.
    logic [REF_BITS-1:0] r_mem_ref [NUM_IDS];
    logic                r_mem_vld [NUM_IDS];

    logic [31:0]   w_hid_m1;
    logic [IW-1:0] w_next_m1;
    logic [IW-1:0] w_scan_len;
    logic [AW-1:0] w_scan_base;
    logic [AW-1:0] w_addr_inc;
    logic          w_issue;
    logic          w_hit_now;
    logic [IW-1:0] w_hit_id;
    logic          w_is_create, w_is_close, w_is_lookup, w_is_reverse;
    logic          w_vld_we;
    logic [AW-1:0] w_vld_wa;
    logic          w_vld_wd;
    logic          w_ref_we;
    t_out_item     w_res;

    assign w_is_create  = (r_action == ACT_CREATE);
    assign w_is_close   = (r_action == ACT_CLOSE);
    assign w_is_lookup  = (r_action == ACT_LOOKUP);
    assign w_is_reverse = (r_action == ACT_REVERSE);

    // Scan window: create walks from the next id, reverse lookup from the
    // first entry, close and lookup read the one addressed entry.
    assign w_hid_m1   = 32'(r_hid) - 32'd1;
    assign w_next_m1  = r_next_id - IW'(1);
    assign w_scan_len = (w_is_close || w_is_lookup) ? IW'(1) : NUM_IDS_W;

    always_comb begin
        if (w_is_create) begin
            w_scan_base = w_next_m1[AW-1:0];
        end else if (w_is_close || w_is_lookup) begin
            w_scan_base = w_hid_m1[AW-1:0];
        end else begin
            w_scan_base = '0;
        end
    end

    assign w_addr_inc = (r_addr == LAST_ADDR) ? '0 : r_addr + AW'(1);
    assign w_issue    = i_cmd.scan && (r_cnt < w_scan_len);

    // Hit test on the entry that the read stage returns.
    always_comb begin
        if (w_is_create) begin
            w_hit_now = r_pend && !r_rd_vbit;
        end else if (w_is_reverse) begin
            w_hit_now = r_pend && r_rd_vbit && (r_rd_ref == r_key);
        end else begin
            w_hit_now = r_pend && r_rd_vbit;
        end
    end

    assign w_hit_id = IW'(r_hit_addr) + IW'(1);

    // Latch the request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_item.action;
            r_key    <= REF_BITS'(i_item.object_ref);
            r_hid    <= i_item.handle_id;
        end
    end

    // Address counter, issue count and read-pending flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_cnt  <= '0;
            r_pend <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_addr <= w_scan_base;
                r_cnt  <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.sweep_start) begin
                r_addr <= '0;
                r_pend <= 1'b0;
            end else begin
                if (w_issue || i_cmd.sweep) begin
                    r_addr <= w_addr_inc;
                end
                if (w_issue) begin
                    r_cnt <= r_cnt + IW'(1);
                end
                r_pend <= w_issue;
            end
        end
    end

    // Registered memory read for the scan.
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_ref  <= r_mem_ref[r_addr];
            r_rd_vbit <= r_mem_vld[r_addr];
            r_rd_addr <= r_addr;
            r_last    <= (r_cnt == w_scan_len - IW'(1));
        end
    end

    // Memory write selection: sweep clears, create sets, close clears.
    always_comb begin
        w_vld_we = 1'b0;
        w_vld_wa = r_hit_addr;
        w_vld_wd = 1'b0;
        if (i_cmd.sweep) begin
            w_vld_we = 1'b1;
            w_vld_wa = r_addr;
        end else if (i_cmd.finish && r_found && w_is_create) begin
            w_vld_we = 1'b1;
            w_vld_wd = 1'b1;
        end else if (i_cmd.finish && r_found && w_is_close) begin
            w_vld_we = 1'b1;
        end
    end

    assign w_ref_we = i_cmd.finish && r_found && w_is_create;

    always_ff @(posedge i_clk) begin
        if (w_vld_we) begin
            r_mem_vld[w_vld_wa] <= w_vld_wd;
        end
        if (w_ref_we) begin
            r_mem_ref[r_hit_addr] <= r_key;
        end
    end

    // Capture the first hit of a scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_found <= 1'b0;
        end else if (i_cmd.scan && w_hit_now) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && w_hit_now) begin
            r_hit_addr <= r_rd_addr;
            r_hit_ref  <= r_rd_ref;
        end
    end

    // Next id, wrap flag and live count.
    always_comb begin
        n_next_id = r_next_id;
        n_wrapped = r_wrapped;
        n_live    = r_live;
        if (i_cmd.sweep_start) begin
            n_next_id = IW'(1);
            n_wrapped = 1'b0;
            n_live    = '0;
        end else if (i_cmd.finish && r_found && w_is_create) begin
            n_live = r_live + IW'(1);
            if (r_hit_addr == LAST_ADDR) begin
                n_next_id = IW'(1);
                n_wrapped = 1'b1;
            end else begin
                n_next_id = IW'(r_hit_addr) + IW'(2);
            end
        end else if (i_cmd.finish && r_found && w_is_close) begin
            if (r_live != '0) begin
                n_live = r_live - IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_id <= IW'(1);
            r_wrapped <= 1'b0;
            r_live    <= '0;
        end else begin
            r_next_id <= n_next_id;
            r_wrapped <= n_wrapped;
            r_live    <= n_live;
        end
    end

    // Result fields; everything stays zero unless the action found or made an entry.
    always_comb begin
        w_res.ok         = r_found;
        w_res.result_id  = '0;
        w_res.result_ref = '0;
        if (r_found && (w_is_create || w_is_reverse)) begin
            w_res.result_id = 9'(w_hit_id);
        end
        if (r_found && w_is_lookup) begin
            w_res.result_ref = 32'(r_hit_ref);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Status toward the controller.
    assign o_stat.action     = r_action;
    assign o_stat.full       = (r_live == NUM_IDS_W);
    assign o_stat.key_null   = (r_key == '0);
    assign o_stat.hid_ok     = (r_hid != 9'd0) && (32'(r_hid) <= 32'(NUM_IDS));
    assign o_stat.hit        = w_hit_now;
    assign o_stat.miss_done  = r_pend && r_last && !w_hit_now;
    assign o_stat.sweep_last = (r_addr == LAST_ADDR);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

endmodule

### src/hida_ctrl.sv
// Controller of the handle id allocator table: sequences accept, decode,
// scan, clearing sweep and result write.
// Depends on hida_pkg.
module hida_ctrl
    import hida_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_CLEAR  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_clr_item, n_clr_item;

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_clr_item = r_clr_item;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.action)
                    ACT_CREATE: begin
                        if (i_stat.full || i_stat.key_null) begin
                            n_state = S_FINISH;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    ACT_CLOSE, ACT_LOOKUP: begin
                        if (!i_stat.hid_ok) begin
                            n_state = S_FINISH;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    ACT_REVERSE: begin
                        if (i_stat.key_null) begin
                            n_state = S_FINISH;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    ACT_CLEAR: begin
                        o_cmd.sweep_start = 1'b1;
                        n_clr_item        = 1'b1;
                        n_state           = S_CLEAR;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.hit || i_stat.miss_done) begin
                    n_state = S_FINISH;
                end
            end
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_clr_item = 1'b0;
                    n_state    = r_clr_item ? S_FINISH : S_IDLE;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers; reset starts with a sweep of the valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_item <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_item <= n_clr_item;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

### dv/tb.sv
// Testbench for handle_id_allocator_table: random and directed requests with a scoreboard.
// A shadow handle table predicts every result item and compares it field by field.
// Depends on hida_pkg and the handle_id_allocator_table RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hida_pkg::*;

    localparam int NUM_IDS       = 256;
    localparam int REF_BITS      = 32;
    localparam int FILL_ITEMS    = 320;
    localparam int MIXED_ITEMS   = 100;
    localparam int QUIET_FROM    = FILL_ITEMS + 50;
    localparam int HOLD_AFTER    = 60;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_CYCLES  = 300;
    localparam int WATCHDOG_MAX  = 5000;

    // Action codes that the block treats as no operation.
    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_MID   = 3'd6;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    // Shadow copy of the handle table plus the queue of results it predicts.
    class handle_table_sb;
        logic [31:0] ref_mem [1:NUM_IDS];
        bit          live [1:NUM_IDS];
        int unsigned next_id;
        bit          wrapped;
        int unsigned live_count;
        t_out_item   pending_results [$];
        int          errors;
        int          checked;

        function new();
            errors  = 0;
            checked = 0;
            empty_table();
        endfunction

        function void empty_table();
            for (int k = 1; k <= NUM_IDS; k++) begin
                ref_mem[k] = '0;
                live[k]    = 1'b0;
            end
            next_id    = 1;
            wrapped    = 1'b0;
            live_count = 0;
        endfunction

        // Work out the result of one accepted request and update the shadow table.
        function void take_request(t_in_item req);
            t_out_item   res;
            int unsigned id;
            int          n;
            res = '0;
            case (req.action)
                ACT_CREATE: begin
                    if (live_count < NUM_IDS && req.object_ref != '0) begin
                        id = (next_id < 1 || next_id > NUM_IDS) ? 1 : next_id;
                        // After the first wrap, hunt forward for a free id.
                        if (wrapped) begin
                            for (n = 0; n < NUM_IDS && live[id]; n++)
                                id = (id >= NUM_IDS) ? 1 : id + 1;
                        end
                        live[id]    = 1'b1;
                        ref_mem[id] = req.object_ref;
                        live_count++;
                        if (id >= NUM_IDS) begin
                            next_id = 1;
                            wrapped = 1'b1;
                        end else begin
                            next_id = id + 1;
                        end
                        res.ok        = 1'b1;
                        res.result_id = 9'(id);
                    end
                end
                ACT_CLOSE: begin
                    if (req.handle_id >= 1 && req.handle_id <= NUM_IDS && live[req.handle_id]) begin
                        live[req.handle_id] = 1'b0;
                        if (live_count > 0)
                            live_count--;
                        res.ok = 1'b1;
                    end
                end
                ACT_LOOKUP: begin
                    if (req.handle_id >= 1 && req.handle_id <= NUM_IDS && live[req.handle_id]) begin
                        res.ok         = 1'b1;
                        res.result_ref = ref_mem[req.handle_id];
                    end
                end
                ACT_REVERSE: begin
                    // Lowest live id holding the reference; null never matches.
                    if (req.object_ref != '0) begin
                        for (n = 1; n <= NUM_IDS && !res.ok; n++) begin
                            if (live[n] && ref_mem[n] == req.object_ref) begin
                                res.ok        = 1'b1;
                                res.result_id = 9'(n);
                            end
                        end
                    end
                end
                ACT_CLEAR: empty_table();
                default: ;
            endcase
            pending_results.push_back(res);
        endfunction

        // Compare one accepted result item with the oldest prediction.
        function void match_result(t_out_item got);
            t_out_item want;
            checked++;
            if (pending_results.size() == 0) begin
                $error("unexpected result item: ok=%0d id=%0d ref=%h",
                       got.ok, got.result_id, got.result_ref);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.ok !== want.ok) begin
                $error("ok: expected %0d, got %0d", want.ok, got.ok);
                errors++;
            end
            if (got.result_id !== want.result_id) begin
                $error("result_id: expected %0d, got %0d", want.result_id, got.result_id);
                errors++;
            end
            if (got.result_ref !== want.result_ref) begin
                $error("result_ref: expected %h, got %h", want.result_ref, got.result_ref);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Try up to 17 random ids and return the first live one, else the last one tried.
        function logic [8:0] pick_live_id();
            logic [8:0] id;
            id = 9'($urandom_range(1, NUM_IDS));
            for (int k = 0; k < 16 && !live[id]; k++)
                id = 9'($urandom_range(1, NUM_IDS));
            return id;
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    handle_table_sb sb = new();
    logic [31:0]    ref_pool [6];
    bit             idle_on;

    handle_id_allocator_table #(
        .NUM_IDS  (NUM_IDS),
        .REF_BITS (REF_BITS)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    // Clock with a 2 ns period.
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Note every accepted request and check every accepted result at the rising edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.take_request(in_item);
            if (out_valid && !out_stall)
                sb.match_result(out_item);
        end
    end

    function automatic t_in_item make_req(logic [2:0] act, logic [31:0] obj, logic [8:0] hid);
        t_in_item req;
        req.action     = act;
        req.object_ref = obj;
        req.handle_id  = hid;
        return req;
    endfunction

    // Offer one item at a falling edge and hold it until the block takes it.
    task automatic send_item(input t_in_item req);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_ref();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        if (roll < 35)
            return ref_pool[$urandom_range(0, 5)];
        return $urandom();
    endfunction

    function automatic logic [8:0] pick_id();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return sb.pick_live_id();
        if (roll < 90)
            return 9'($urandom_range(1, NUM_IDS));
        return 9'($urandom_range(0, 511));
    endfunction

    // Reverse lookups mostly aim at a stored reference so that they can hit.
    function automatic logic [31:0] pick_reverse_ref();
        logic [8:0] id;
        id = sb.pick_live_id();
        if ($urandom_range(0, 1) == 0 && sb.live[id])
            return sb.ref_mem[id];
        return pick_ref();
    endfunction

    // One random item; the fill mix drives the table past its first wrap, the
    // mixed mix fills it up and throws in clears and junk.
    function automatic t_in_item random_req(bit fill_phase);
        int         roll;
        logic [2:0] act;
        roll = $urandom_range(0, 99);
        if (fill_phase) begin
            if (roll < 82)      act = ACT_CREATE;
            else if (roll < 92) act = ACT_CLOSE;
            else if (roll < 95) act = ACT_LOOKUP;
            else if (roll < 98) act = ACT_REVERSE;
            else                act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
        end else begin
            if (roll < 40)      act = ACT_CREATE;
            else if (roll < 65) act = ACT_CLOSE;
            else if (roll < 77) act = ACT_LOOKUP;
            else if (roll < 92) act = ACT_REVERSE;
            else if (roll < 96) act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
            else if (roll < 98) act = ACT_CLEAR;
            else                act = 3'($urandom());
        end
        if (act == ACT_REVERSE)
            return make_req(act, pick_reverse_ref(), 9'($urandom()));
        return make_req(act, pick_ref(), pick_id());
    endfunction

    // Receiver: random stall bursts, one long hold to back up the block, then none.
    initial begin : receiver
        bit held;
        held      = 1'b0;
        out_stall = 1'b0;
        @(negedge clk);
        while (!rst_n)
            @(negedge clk);
        forever begin
            if (!held && sb.checked >= HOLD_AFTER) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
    end

    // Watchdog: ends the run when nothing moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_MAX) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: errors");
        $finish;
    end

    // Stimulus: reset, directed corner cases, random items, then drain.
    initial begin : stimulus
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        idle_on  = 1'b1;
        for (int k = 0; k < 6; k++)
            ref_pool[k] = $urandom() | 32'h1;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table, null and extreme references, duplicates, bad ids.
        send_item(make_req(ACT_LOOKUP, '0, 9'd1));
        send_item(make_req(ACT_CLOSE, '0, 9'd0));
        send_item(make_req(ACT_CREATE, '0, 9'd0));
        send_item(make_req(ACT_CREATE, 32'hFFFF_FFFF, 9'h1FF));
        send_item(make_req(ACT_CREATE, 32'h0000_0001, 9'd0));
        send_item(make_req(ACT_CREATE, 32'hFFFF_FFFF, 9'd0));
        send_item(make_req(ACT_REVERSE, 32'hFFFF_FFFF, 9'd0));
        send_item(make_req(ACT_REVERSE, '0, 9'd0));
        send_item(make_req(ACT_REVERSE, 32'h1234_5678, 9'd0));
        send_item(make_req(ACT_LOOKUP, '0, 9'd1));
        send_item(make_req(ACT_LOOKUP, '0, 9'd0));
        send_item(make_req(ACT_LOOKUP, '0, 9'(NUM_IDS)));
        send_item(make_req(ACT_LOOKUP, '0, 9'h1FF));
        send_item(make_req(ACT_CLOSE, '0, 9'd1));
        send_item(make_req(ACT_CLOSE, '0, 9'd1));
        send_item(make_req(ACT_REVERSE, 32'hFFFF_FFFF, 9'd0));
        send_item(make_req(ACT_CLOSE, '0, 9'h1FF));
        // Unused codes with every field set, then clear and a counter restart.
        send_item(make_req(ACT_SPARE_FIRST, 32'hFFFF_FFFF, 9'h1FF));
        send_item(make_req(ACT_SPARE_MID, 32'hFFFF_FFFF, 9'h1FF));
        send_item(make_req(ACT_SPARE_LAST, 32'hFFFF_FFFF, 9'h1FF));
        send_item(make_req(ACT_CLEAR, 32'hFFFF_FFFF, 9'h1FF));
        send_item(make_req(ACT_LOOKUP, '0, 9'd2));
        send_item(make_req(ACT_CREATE, 32'h8000_0000, 9'd0));

        for (int k = 0; k < FILL_ITEMS + MIXED_ITEMS; k++) begin
            if (k == QUIET_FROM)
                idle_on = 1'b0;
            send_item(random_req(k < FILL_ITEMS));
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

### filelist.f
src/hida_pkg.sv
src/hida_dpath.sv
src/hida_ctrl.sv
src/handle_id_allocator_table.sv
dv/tb.sv
